@@ src/sfcrc_pkg.sv @@
package sfcrc_pkg;

  localparam int MAX_PAYLOAD_DEF = 64;

  localparam logic [7:0]  SYNC_BYTE  = 8'hAA;
  localparam logic [7:0]  TRAIL_BYTE = 8'h55;
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

  // item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // result kinds
  localparam logic RES_FRAME   = 1'b0;
  localparam logic RES_TIMEOUT = 1'b1;

  // register index (paddr[2])
  localparam logic REG_TIMEOUT_ENABLE = 1'b0;
  localparam logic REG_TIMEOUT_TICKS  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] frame_id;
    logic [6:0] frame_length;
    logic [5:0] byte_index;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last;
  } result_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

@@ src/stuffed_frame_crc32_receiver.sv @@
// channel | dir | handshake                    | payload
// item    | in  | item_valid / item_ready      | item   (kind, data)
// result  | out | result_valid / result_ready  | result (byte, empty or timeout)
// config  | in  | APB psel/penable/pwrite      | timeout_enable @0, timeout_ticks @4
//
// Items are taken while ctrl is CT_RUN, so an item that starts no result lets
// the next one be taken in the following cycle. A good frame is replayed from
// the payload RAM byte by byte (RAM read, then output register load); input is
// held off until the run is handed over. Zero-length and timeout results are
// loaded once the output register frees. Reset is synchronous; the payload RAM
// needs no clearing. A stalled result blocks input only while a new one waits.
module stuffed_frame_crc32_receiver #(
  parameter int MAX_PAYLOAD = sfcrc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  sfcrc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output sfcrc_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import sfcrc_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  typedef enum logic [3:0] {
    PH_SEARCH, PH_ID, PH_LEN, PH_DATA, PH_CRC3, PH_CRC2, PH_CRC1, PH_CRC0, PH_EOF
  } phase_t;

  typedef enum logic [2:0] {
    CT_RUN, CT_EMIT_RD, CT_EMIT_WR, CT_PEND_ZERO, CT_PEND_TIMEOUT
  } ctrl_t;

  logic        timeout_enable;
  logic [31:0] timeout_ticks;

  phase_t      phase;
  ctrl_t       ctrl;
  logic [1:0]  header_run;
  logic [7:0]  frame_ident;
  logic [6:0]  stored_length;
  logic [6:0]  bytes_remaining;
  logic [6:0]  write_position;
  logic [31:0] crc_running;
  logic [31:0] crc_received;
  logic [31:0] idle_count;
  logic [6:0]  emit_count;

  // payload RAM
  logic [7:0]    store [MAX_PAYLOAD];
  logic          store_we;
  logic [AW-1:0] store_waddr;
  logic [7:0]    store_wdata;
  logic          store_re;
  logic [AW-1:0] store_raddr;
  logic [7:0]    store_rdata;

  logic        accept;
  logic        is_byte;
  logic [7:0]  b;
  logic [31:0] crc_next;
  logic [31:0] crc_full;
  logic [31:0] idle_inc;
  logic        tick_hit;
  logic        slot_free;
  logic        res_load;
  logic        emit_last;
  logic        cfg_write;

  assign pready     = 1'b1;
  assign cfg_write  = psel & penable & pwrite;
  assign prdata     = (paddr[2] == REG_TIMEOUT_TICKS) ? timeout_ticks
                                                      : {31'd0, timeout_enable};

  assign item_ready = (ctrl == CT_RUN);
  assign accept     = item_valid & item_ready;
  assign is_byte    = (item.kind == KIND_BYTE);
  assign b          = item.data;
  assign slot_free  = ~result_valid | result_ready;
  assign res_load   = slot_free & ((ctrl == CT_EMIT_WR) | (ctrl == CT_PEND_ZERO)
                                   | (ctrl == CT_PEND_TIMEOUT));

  assign crc_next   = crc_byte((phase == PH_ID) ? CRC_INIT : crc_running, b);
  assign crc_full   = {crc_received[31:8], b};
  assign idle_inc   = (idle_count == '1) ? idle_count : idle_count + 32'd1;
  // new count >= ticks, with saturation folded into the 33-bit sum
  assign tick_hit   = ({1'b0, idle_count} + 33'd1) >= {1'b0, timeout_ticks};
  assign emit_last  = ((emit_count + 7'd1) == stored_length);

  assign store_we    = accept & is_byte & (header_run != 2'd2) & (phase == PH_DATA)
                       & (write_position < 7'(MAX_PAYLOAD));
  assign store_waddr = write_position[AW-1:0];
  assign store_wdata = b;
  assign store_re    = (ctrl == CT_EMIT_RD);
  assign store_raddr = emit_count[AW-1:0];

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[store_waddr] <= store_wdata;
    end
    if (store_re) begin
      store_rdata <= store[store_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_enable <= 1'b0;
      timeout_ticks  <= 32'd100;
    end else if (cfg_write) begin
      if (paddr[2] == REG_TIMEOUT_ENABLE) begin
        timeout_enable <= pwdata[0];
      end else begin
        timeout_ticks <= pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SEARCH;
      ctrl         <= CT_RUN;
      header_run   <= 2'd0;
      idle_count   <= 32'd0;
      crc_running  <= CRC_INIT;
      crc_received <= 32'd0;
      frame_ident  <= 8'd0;
      stored_length   <= 7'd0;
      write_position  <= 7'd0;
      bytes_remaining <= 7'd0;
      emit_count      <= 7'd0;
    end else begin
      case (ctrl)
        CT_RUN: begin
          if (accept && !is_byte) begin
            if (phase != PH_SEARCH && timeout_enable && tick_hit) begin
              idle_count      <= 32'd0;
              crc_running     <= CRC_INIT;
              header_run      <= 2'd0;
              write_position  <= 7'd0;
              bytes_remaining <= 7'd0;
              phase           <= PH_SEARCH;
              ctrl            <= CT_PEND_TIMEOUT;
            end else begin
              idle_count <= idle_inc;
            end
          end else if (accept) begin
            idle_count <= 32'd0;
            if (header_run == 2'd2) begin
              // byte after two sync bytes: restart, stuff or abort
              header_run <= 2'd0;
              if (b == SYNC_BYTE) begin
                phase <= PH_ID;
              end else if (b != TRAIL_BYTE) begin
                phase <= PH_SEARCH;
              end
            end else begin
              header_run <= (b == SYNC_BYTE) ? header_run + 2'd1 : 2'd0;
              case (phase)
                PH_ID: begin
                  frame_ident    <= b;
                  write_position <= 7'd0;
                  crc_running    <= crc_next;
                  phase          <= PH_LEN;
                end
                PH_LEN: begin
                  crc_running <= crc_next;
                  if (b == 8'd0) begin
                    stored_length   <= 7'd0;
                    bytes_remaining <= 7'd0;
                    phase           <= PH_CRC3;
                  end else if ({24'd0, b} <= 32'(MAX_PAYLOAD)) begin
                    stored_length   <= b[6:0];
                    bytes_remaining <= b[6:0];
                    phase           <= PH_DATA;
                  end else begin
                    phase <= PH_SEARCH;
                  end
                end
                PH_DATA: begin
                  if (store_we) begin
                    write_position <= write_position + 7'd1;
                  end
                  crc_running     <= crc_next;
                  bytes_remaining <= bytes_remaining - 7'd1;
                  if (bytes_remaining == 7'd1) begin
                    phase <= PH_CRC3;
                  end
                end
                PH_CRC3: begin
                  crc_received <= {b, 24'd0};
                  phase        <= PH_CRC2;
                end
                PH_CRC2: begin
                  crc_received[23:16] <= b;
                  phase               <= PH_CRC1;
                end
                PH_CRC1: begin
                  crc_received[15:8] <= b;
                  phase              <= PH_CRC0;
                end
                PH_CRC0: begin
                  crc_received <= crc_full;
                  phase <= (crc_full == ~crc_running) ? PH_EOF : PH_SEARCH;
                end
                PH_EOF: begin
                  phase <= PH_SEARCH;
                  if (b == TRAIL_BYTE) begin
                    emit_count <= 7'd0;
                    ctrl <= (stored_length == 7'd0) ? CT_PEND_ZERO : CT_EMIT_RD;
                  end
                end
                default: begin
                  phase <= PH_SEARCH;
                end
              endcase
            end
          end
        end

        CT_EMIT_RD: begin
          ctrl <= CT_EMIT_WR;
        end

        CT_EMIT_WR: begin
          if (slot_free) begin
            result <= '{result_kind: RES_FRAME, frame_id: frame_ident,
                        frame_length: stored_length, byte_index: emit_count[5:0],
                        payload_byte: store_rdata, byte_valid: 1'b1,
                        last: emit_last};
            emit_count <= emit_count + 7'd1;
            ctrl <= emit_last ? CT_RUN : CT_EMIT_RD;
          end
        end

        CT_PEND_ZERO: begin
          if (slot_free) begin
            result <= '{result_kind: RES_FRAME, frame_id: frame_ident,
                        frame_length: 7'd0, byte_index: 6'd0, payload_byte: 8'd0,
                        byte_valid: 1'b0, last: 1'b1};
            ctrl <= CT_RUN;
          end
        end

        CT_PEND_TIMEOUT: begin
          if (slot_free) begin
            result <= '{result_kind: RES_TIMEOUT, frame_id: 8'd0,
                        frame_length: 7'd0, byte_index: 6'd0, payload_byte: 8'd0,
                        byte_valid: 1'b0, last: 1'b1};
            ctrl <= CT_RUN;
          end
        end

        default: begin
          ctrl <= CT_RUN;
        end
      endcase
    end
  end

endmodule

@@ src/sfcrc_checker.sv @@
module sfcrc_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input sfcrc_pkg::result_t result
);
  import sfcrc_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // a timeout is a lone, empty result
  a_timeout: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind == RES_TIMEOUT |->
      result.last && !result.byte_valid && result.frame_length == 7'd0)
    else $error("malformed timeout result");

  // empty frame result only for zero length, and it closes the run
  a_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind == RES_FRAME && !result.byte_valid |->
      result.last && result.frame_length == 7'd0)
    else $error("empty result outside zero-length frame");

  // byte position inside the frame, last on the final one
  a_index: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.byte_valid |->
      ({1'b0, result.byte_index} < result.frame_length) &&
      (result.last == (({1'b0, result.byte_index} + 7'd1) == result.frame_length)))
    else $error("byte index out of frame or wrong last");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind stuffed_frame_crc32_receiver sfcrc_checker u_sfcrc_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
